[rtl/spmt_pkg.sv]
// Shared types and constants of the store pattern trace monitor.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package spmt_pkg;

  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned InDataW  = 328;
  localparam int unsigned OutDataW = 272;

  localparam logic [2:0] RegWindowLow  = 3'd0;
  localparam logic [2:0] RegWindowHigh = 3'd1;
  localparam logic [2:0] RegFaultA     = 3'd2;
  localparam logic [2:0] RegFaultB     = 3'd3;
  localparam logic [2:0] RegFillEntry  = 3'd4;

  localparam logic [1:0] OpBlock = 2'd0;
  localparam logic [1:0] OpStore = 2'd1;

  localparam logic [2:0] Size1  = 3'd0;
  localparam logic [2:0] Size2  = 3'd1;
  localparam logic [2:0] Size4  = 3'd2;
  localparam logic [2:0] Size8  = 3'd3;
  localparam logic [2:0] Size16 = 3'd4;

  localparam logic [2:0] KindMatch       = 3'd0;
  localparam logic [2:0] KindMatchTrace  = 3'd1;
  localparam logic [2:0] KindFaultHdr    = 3'd2;
  localparam logic [2:0] KindFaultTrace  = 3'd3;
  localparam logic [2:0] KindCallerHdr   = 3'd4;
  localparam logic [2:0] KindCallerTrace = 3'd5;

  localparam logic [7:0]  Aa8  = 8'hAA;
  localparam logic [15:0] Aa16 = 16'hAAAA;
  localparam logic [31:0] Aa32 = 32'hAAAAAAAA;
  localparam logic [63:0] Aa64 = 64'hAAAAAAAAAAAAAAAA;

  typedef enum logic [3:0] {
    StClear, StIdle, StDecode, StSelf, StCaller, StSearch, StDump, StFlush, StPost, StAppend
  } state_e;

  typedef enum logic [1:0] {PendMatch, PendFault, PendCaller} pend_src_e;

  typedef struct packed {
    logic [63:0] window_low;
    logic [63:0] window_high;
    logic [63:0] fault_a;
    logic [63:0] fault_b;
    logic [63:0] fill_entry;
  } cfg_t;

  typedef struct packed {
    logic       latch;
    logic       clr_step;
    logic       append;
    logic       idx_clr;
    logic       idx_inc;
    logic       cap_self;
    logic       cap_caller;
    logic       srch_clr;
    logic       srch_inc;
    logic       srch_cal;
    logic       tbl_add;
    logic       match_inc;
    logic       pend_load;
    pend_src_e  pend_src;
    logic       pend_trace;
    logic [2:0] trace_kind;
    logic       emit;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       is_fault;
    logic       is_fill;
    logic       ring_ge2;
    logic       store_match;
    logic       out_free;
    logic       rd_zero;
    logic       clr_last;
    logic       srch_end;
    logic       srch_hit;
    logic       tbl_full;
    logic [6:0] idx;
  } sts_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq_count;
    logic [63:0] addr_a;
    logic [63:0] addr_b;
    logic [63:0] data_value;
    logic [4:0]  width_bytes;
    logic [6:0]  trace_index;
    logic [31:0] ring_position;
    logic        last;
  } res_t;

endpackage

[rtl/spmt_regs.sv]
// Configuration register file with its APB-style access port.
// Depends on spmt_pkg.
`timescale 1ns / 1ps

module spmt_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spmt_pkg::CfgAddrW-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  output spmt_pkg::cfg_t               cfg_o
);

  spmt_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     sel;

  assign sel    = paddr[5:3];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (sel)
        spmt_pkg::RegWindowLow:  cfg_d.window_low  = pwdata;
        spmt_pkg::RegWindowHigh: cfg_d.window_high = pwdata;
        spmt_pkg::RegFaultA:     cfg_d.fault_a     = pwdata;
        spmt_pkg::RegFaultB:     cfg_d.fault_b     = pwdata;
        spmt_pkg::RegFillEntry:  cfg_d.fill_entry  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      spmt_pkg::RegWindowLow:  prdata = cfg_q.window_low;
      spmt_pkg::RegWindowHigh: prdata = cfg_q.window_high;
      spmt_pkg::RegFaultA:     prdata = cfg_q.fault_a;
      spmt_pkg::RegFaultB:     prdata = cfg_q.fault_b;
      spmt_pkg::RegFillEntry:  prdata = cfg_q.fill_entry;
      default:                 prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low  <= 64'h0000_0040_0000_0000;
      cfg_q.window_high <= 64'h0000_8000_0000_0000;
      cfg_q.fault_a     <= 64'h0000_0000_0010_D101;
      cfg_q.fault_b     <= 64'h0000_0000_0010_D108;
      cfg_q.fill_entry  <= 64'h0000_0040_00D9_B800;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/spmt_dp.sv]
// Datapath: item registers, block ring, seen-address tables, counters,
// pending result and output register. Depends on spmt_pkg.
`timescale 1ns / 1ps

module spmt_dp #(
  parameter int unsigned RING_DEPTH     = 512,
  parameter int unsigned SITE_ENTRIES   = 128,
  parameter int unsigned CALLER_ENTRIES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spmt_pkg::cfg_t               cfg_i,
  input  spmt_pkg::cmd_t               cmd_i,
  input  logic [1:0]                   in_user_i,
  input  logic [spmt_pkg::InDataW-1:0] in_data_i,
  input  logic                         out_ready_i,
  output spmt_pkg::sts_t               sts_o,
  output logic                         out_valid_o,
  output spmt_pkg::res_t               out_res_o
);

  localparam int unsigned RingAw = $clog2(RING_DEPTH);
  localparam int unsigned SiteAw = (SITE_ENTRIES > 1) ? $clog2(SITE_ENTRIES) : 1;
  localparam int unsigned SiteCw = $clog2(SITE_ENTRIES + 1);
  localparam int unsigned CalAw  = (CALLER_ENTRIES > 1) ? $clog2(CALLER_ENTRIES) : 1;
  localparam int unsigned CalCw  = $clog2(CALLER_ENTRIES + 1);
  localparam int unsigned SrchW  = (SiteCw > CalCw) ? SiteCw : CalCw;
  localparam logic [RingAw-1:0] RingLast = RingAw'(RING_DEPTH - 1);

  logic [1:0]  op_q;
  logic [63:0] blk_q, st_addr_q, lo_q, hi_q, instr_q;
  logic [2:0]  size_q;

  logic [63:0]       ring_mem [RING_DEPTH];
  logic [63:0]       ring_rdata_q;
  logic [RingAw-1:0] wp_q, rp_q, rp_d, clr_q;
  logic [31:0]       ring_count_q, match_count_q, caller_cnt_q;
  logic [6:0]        idx_q;
  logic [63:0]       self_q, caller_q;

  logic [63:0]       site_mem [SITE_ENTRIES];
  logic [63:0]       cal_mem [CALLER_ENTRIES];
  logic [63:0]       site_rdata_q, cal_rdata_q;
  logic [SiteCw-1:0] site_used_q;
  logic [CalCw-1:0]  cal_used_q;
  logic [SrchW-1:0]  j_q, j_d;

  spmt_pkg::res_t pend_q, pend_d, out_q;
  logic           out_valid_q;

  logic        in_win, pat_ok;
  logic [63:0] val;
  logic [4:0]  width;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q      <= in_user_i;
      blk_q     <= in_data_i[63:0];
      st_addr_q <= in_data_i[127:64];
      size_q    <= in_data_i[130:128];
      lo_q      <= in_data_i[194:131];
      hi_q      <= in_data_i[258:195];
      instr_q   <= in_data_i[322:259];
    end
  end

  assign in_win = (st_addr_q >= cfg_i.window_low) && (st_addr_q < cfg_i.window_high);

  always_comb begin
    unique case (size_q)
      spmt_pkg::Size1: begin
        pat_ok = lo_q[7:0] == spmt_pkg::Aa8;
        val    = {56'd0, lo_q[7:0]};
        width  = 5'd1;
      end
      spmt_pkg::Size2: begin
        pat_ok = lo_q[15:0] == spmt_pkg::Aa16;
        val    = {48'd0, lo_q[15:0]};
        width  = 5'd2;
      end
      spmt_pkg::Size4: begin
        pat_ok = lo_q[31:0] == spmt_pkg::Aa32;
        val    = {32'd0, lo_q[31:0]};
        width  = 5'd4;
      end
      spmt_pkg::Size8: begin
        pat_ok = lo_q == spmt_pkg::Aa64;
        val    = lo_q;
        width  = 5'd8;
      end
      spmt_pkg::Size16: begin
        pat_ok = (lo_q == spmt_pkg::Aa64) && (hi_q == spmt_pkg::Aa64);
        val    = lo_q;
        width  = 5'd16;
      end
      default: begin
        pat_ok = 1'b0;
        val    = lo_q;
        width  = 5'd0;
      end
    endcase
  end

  always_comb begin
    rp_d = rp_q;
    if (cmd_i.idx_clr) begin
      rp_d = (wp_q == '0) ? RingLast : wp_q - 1'b1;
    end else if (cmd_i.idx_inc) begin
      rp_d = (rp_q == '0) ? RingLast : rp_q - 1'b1;
    end
  end

  always_comb begin
    j_d = j_q;
    if (cmd_i.srch_clr) begin
      j_d = '0;
    end else if (cmd_i.srch_inc) begin
      j_d = j_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      ring_mem[clr_q] <= 64'd0;
    end else if (cmd_i.append) begin
      ring_mem[wp_q] <= blk_q;
    end
    ring_rdata_q <= ring_mem[rp_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_add && !cmd_i.srch_cal) begin
      site_mem[site_used_q[SiteAw-1:0]] <= instr_q;
    end
    site_rdata_q <= site_mem[j_d[SiteAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_add && cmd_i.srch_cal) begin
      cal_mem[cal_used_q[CalAw-1:0]] <= caller_q;
    end
    cal_rdata_q <= cal_mem[j_d[CalAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_self) begin
      self_q <= ring_rdata_q;
    end
    if (cmd_i.cap_caller) begin
      caller_q <= ring_rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q          <= '0;
      rp_q          <= '0;
      clr_q         <= '0;
      ring_count_q  <= 32'd0;
      match_count_q <= 32'd0;
      caller_cnt_q  <= 32'd0;
      idx_q         <= 7'd0;
      site_used_q   <= '0;
      cal_used_q    <= '0;
      j_q           <= '0;
    end else begin
      rp_q <= rp_d;
      j_q  <= j_d;
      if (cmd_i.clr_step) begin
        clr_q <= (clr_q == RingLast) ? '0 : clr_q + 1'b1;
      end
      if (cmd_i.append) begin
        wp_q         <= (wp_q == RingLast) ? '0 : wp_q + 1'b1;
        ring_count_q <= ring_count_q + 32'd1;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= 7'd0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 7'd1;
      end
      if (cmd_i.match_inc) begin
        match_count_q <= match_count_q + 32'd1;
      end
      if (cmd_i.tbl_add) begin
        if (cmd_i.srch_cal) begin
          cal_used_q   <= cal_used_q + 1'b1;
          caller_cnt_q <= caller_cnt_q + 32'd1;
        end else begin
          site_used_q <= site_used_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (cmd_i.pend_load) begin
      pend_d = '0;
      unique case (cmd_i.pend_src)
        spmt_pkg::PendMatch: begin
          pend_d.kind        = spmt_pkg::KindMatch;
          pend_d.seq_count   = match_count_q + 32'd1;
          pend_d.addr_a      = instr_q;
          pend_d.addr_b      = st_addr_q;
          pend_d.data_value  = val;
          pend_d.width_bytes = width;
        end
        spmt_pkg::PendFault: begin
          pend_d.kind          = spmt_pkg::KindFaultHdr;
          pend_d.seq_count     = match_count_q;
          pend_d.ring_position = ring_count_q;
        end
        spmt_pkg::PendCaller: begin
          pend_d.kind      = spmt_pkg::KindCallerHdr;
          pend_d.seq_count = caller_cnt_q + 32'd1;
          pend_d.addr_a    = caller_q;
          pend_d.addr_b    = self_q;
        end
        default: ;
      endcase
    end else if (cmd_i.pend_trace) begin
      pend_d             = '0;
      pend_d.kind        = cmd_i.trace_kind;
      pend_d.addr_a      = ring_rdata_q;
      pend_d.trace_index = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= {pend_q[$bits(spmt_pkg::res_t)-1:1], cmd_i.emit_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_comb begin
    sts_o.opcode      = op_q;
    sts_o.is_fault    = (blk_q == cfg_i.fault_a) || (blk_q == cfg_i.fault_b);
    sts_o.is_fill     = blk_q == cfg_i.fill_entry;
    sts_o.ring_ge2    = ring_count_q >= 32'd2;
    sts_o.store_match = in_win && pat_ok;
    sts_o.out_free    = !out_valid_q || out_ready_i;
    sts_o.rd_zero     = ring_rdata_q == 64'd0;
    sts_o.clr_last    = clr_q == RingLast;
    sts_o.idx         = idx_q;
    if (cmd_i.srch_cal) begin
      sts_o.srch_end = j_q == SrchW'(cal_used_q);
      sts_o.srch_hit = cal_rdata_q == caller_q;
      sts_o.tbl_full = cal_used_q == CalCw'(CALLER_ENTRIES);
    end else begin
      sts_o.srch_end = j_q == SrchW'(site_used_q);
      sts_o.srch_hit = site_rdata_q == instr_q;
      sts_o.tbl_full = site_used_q == SiteCw'(SITE_ENTRIES);
    end
  end

endmodule

[rtl/spmt_ctrl.sv]
// Controller state machine that sequences decode, table searches, ring dumps,
// ring clearing and ring append. Depends on spmt_pkg.
`timescale 1ns / 1ps

module spmt_ctrl #(
  parameter int unsigned STORE_TRACE_DEPTH  = 63,
  parameter int unsigned FAULT_TRACE_DEPTH  = 63,
  parameter int unsigned CALLER_TRACE_DEPTH = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spmt_pkg::sts_t sts_i,
  output spmt_pkg::cmd_t cmd_o
);

  localparam logic [6:0] StoreEnd  = 7'(STORE_TRACE_DEPTH - 1);
  localparam logic [6:0] FaultEnd  = 7'(FAULT_TRACE_DEPTH - 1);
  localparam logic [6:0] CallerEnd = 7'(CALLER_TRACE_DEPTH + 1);

  spmt_pkg::state_e state_q, state_d;
  logic             post_clear_q, post_clear_d;
  logic             srch_cal_q, srch_cal_d;
  logic [2:0]       tkind_q, tkind_d;
  logic [6:0]       end_q, end_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= spmt_pkg::StClear;
      post_clear_q <= 1'b0;
      srch_cal_q   <= 1'b0;
      tkind_q      <= spmt_pkg::KindMatchTrace;
      end_q        <= 7'd0;
    end else begin
      state_q      <= state_d;
      post_clear_q <= post_clear_d;
      srch_cal_q   <= srch_cal_d;
      tkind_q      <= tkind_d;
      end_q        <= end_d;
    end
  end

  assign in_ready_o = state_q == spmt_pkg::StIdle;

  always_comb begin
    state_d          = state_q;
    post_clear_d     = post_clear_q;
    srch_cal_d       = srch_cal_q;
    tkind_d          = tkind_q;
    end_d            = end_q;
    cmd_o            = '0;
    cmd_o.srch_cal   = srch_cal_q;
    cmd_o.trace_kind = tkind_q;
    unique case (state_q)
      spmt_pkg::StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = post_clear_q ? spmt_pkg::StAppend : spmt_pkg::StIdle;
        end
      end
      spmt_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = spmt_pkg::StDecode;
        end
      end
      spmt_pkg::StDecode: begin
        if (sts_i.opcode == spmt_pkg::OpBlock) begin
          if (sts_i.is_fault) begin
            cmd_o.pend_load = 1'b1;
            cmd_o.pend_src  = spmt_pkg::PendFault;
            cmd_o.idx_clr   = 1'b1;
            post_clear_d    = 1'b1;
            tkind_d         = spmt_pkg::KindFaultTrace;
            end_d           = FaultEnd;
            state_d         = spmt_pkg::StDump;
          end else if (sts_i.is_fill && sts_i.ring_ge2) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = spmt_pkg::StSelf;
          end else begin
            state_d = spmt_pkg::StAppend;
          end
        end else if (sts_i.opcode == spmt_pkg::OpStore && sts_i.store_match) begin
          cmd_o.match_inc = 1'b1;
          cmd_o.pend_load = 1'b1;
          cmd_o.pend_src  = spmt_pkg::PendMatch;
          cmd_o.srch_clr  = 1'b1;
          srch_cal_d      = 1'b0;
          tkind_d         = spmt_pkg::KindMatchTrace;
          end_d           = StoreEnd;
          state_d         = spmt_pkg::StSearch;
        end else begin
          state_d = spmt_pkg::StIdle;
        end
      end
      spmt_pkg::StSelf: begin
        cmd_o.cap_self = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = spmt_pkg::StCaller;
      end
      spmt_pkg::StCaller: begin
        cmd_o.cap_caller = 1'b1;
        cmd_o.srch_clr   = 1'b1;
        srch_cal_d       = 1'b1;
        tkind_d          = spmt_pkg::KindCallerTrace;
        end_d            = CallerEnd;
        state_d          = spmt_pkg::StSearch;
      end
      spmt_pkg::StSearch: begin
        priority if (sts_i.srch_end) begin
          if (sts_i.tbl_full) begin
            state_d = srch_cal_q ? spmt_pkg::StAppend : spmt_pkg::StFlush;
          end else begin
            cmd_o.tbl_add = 1'b1;
            if (srch_cal_q) begin
              cmd_o.pend_load = 1'b1;
              cmd_o.pend_src  = spmt_pkg::PendCaller;
              cmd_o.idx_inc   = 1'b1;
            end else begin
              cmd_o.idx_clr = 1'b1;
            end
            state_d = spmt_pkg::StDump;
          end
        end else if (sts_i.srch_hit) begin
          state_d = srch_cal_q ? spmt_pkg::StAppend : spmt_pkg::StFlush;
        end else begin
          cmd_o.srch_inc = 1'b1;
        end
      end
      spmt_pkg::StDump: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.rd_zero) begin
            cmd_o.emit_last = 1'b1;
            state_d         = spmt_pkg::StPost;
          end else begin
            cmd_o.pend_trace = 1'b1;
            if (sts_i.idx == end_q) begin
              state_d = spmt_pkg::StFlush;
            end else begin
              cmd_o.idx_inc = 1'b1;
            end
          end
        end
      end
      spmt_pkg::StFlush: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = spmt_pkg::StPost;
        end
      end
      spmt_pkg::StPost: begin
        priority if (post_clear_q) begin
          state_d = spmt_pkg::StClear;
        end else if (sts_i.opcode == spmt_pkg::OpBlock) begin
          state_d = spmt_pkg::StAppend;
        end else begin
          state_d = spmt_pkg::StIdle;
        end
      end
      spmt_pkg::StAppend: begin
        cmd_o.append = 1'b1;
        post_clear_d = 1'b0;
        state_d      = spmt_pkg::StIdle;
      end
      default: state_d = spmt_pkg::StIdle;
    endcase
  end

endmodule

[rtl/store_pattern_trace_monitor_top.sv]
// Top level of the store pattern trace monitor: register file, controller
// and datapath. Depends on spmt_pkg, spmt_regs, spmt_ctrl and spmt_dp.
//
// Debug events enter on the slave stream (s_tuser carries the event kind),
// result records leave on the master stream with m_tlast on the final record
// of each event. The user must write registers over the APB-style port only
// while idle; the block itself does not enforce it. One event is processed at
// a time. A matching store searches the seen-site table entry by entry, and a
// fill entry searches the seen-caller table. Each dumped ring entry is read
// through the ring memory read port. A fault handler hit is followed by a ring
// clearing pass over every ring entry. After reset the same clearing pass runs
// before the first event is taken. When the receiver stalls, the record stays
// in the output register and the dump waits; the next event is taken once the
// current one has issued all records.
`timescale 1ns / 1ps

module store_pattern_trace_monitor_top #(
  parameter int unsigned RING_DEPTH         = 512,
  parameter int unsigned SITE_ENTRIES       = 128,
  parameter int unsigned CALLER_ENTRIES     = 64,
  parameter int unsigned STORE_TRACE_DEPTH  = 63,
  parameter int unsigned FAULT_TRACE_DEPTH  = 63,
  parameter int unsigned CALLER_TRACE_DEPTH = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // block_addr, store_addr, size_code, data_low, data_high, instr_addr
  input  logic [spmt_pkg::InDataW-1:0]  s_tdata,
  // opcode
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // seq_count, addr_a, addr_b, data_value, width_bytes, trace_index, ring_position
  output logic [spmt_pkg::OutDataW-1:0] m_tdata,
  // kind
  output logic [2:0]                    m_tuser,
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spmt_pkg::CfgAddrW-1:0] paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  spmt_pkg::cfg_t cfg;
  spmt_pkg::cmd_t cmd;
  spmt_pkg::sts_t sts;
  spmt_pkg::res_t res;

  spmt_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  spmt_ctrl #(
    .STORE_TRACE_DEPTH (STORE_TRACE_DEPTH),
    .FAULT_TRACE_DEPTH (FAULT_TRACE_DEPTH),
    .CALLER_TRACE_DEPTH(CALLER_TRACE_DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_tvalid),
    .in_ready_o(s_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  spmt_dp #(
    .RING_DEPTH    (RING_DEPTH),
    .SITE_ENTRIES  (SITE_ENTRIES),
    .CALLER_ENTRIES(CALLER_ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .in_user_i  (s_tuser),
    .in_data_i  (s_tdata),
    .out_ready_i(m_tready),
    .sts_o      (sts),
    .out_valid_o(m_tvalid),
    .out_res_o  (res)
  );

  assign m_tdata = {4'd0, res.ring_position, res.trace_index, res.width_bytes,
                    res.data_value, res.addr_b, res.addr_a, res.seq_count};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

`ifndef SYNTH
  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("record issued while output register still occupied");

  a_table_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tbl_add |-> !sts.tbl_full)
    else $error("seen table written beyond its capacity");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second event taken while one is in progress");
`endif

endmodule
